// ===== rtl/segaabb_pkg.sv =====
`timescale 1ns / 1ps

package segaabb_pkg;

    // Port width of every coordinate field
    localparam int IN_WIDTH    = 32;
    // Bits of each coordinate that take part in the test (sign-extended from the top one)
    localparam int COORD_WIDTH = 32;
    localparam int EPS_WIDTH   = 8;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);

    typedef logic [IN_WIDTH-1:0]               in_t;
    typedef logic [EPS_WIDTH-1:0]              eps_t;
    typedef logic signed [COORD_WIDTH-1:0]     coord_t;
    // Doubled midpoint offset: sum of four coordinates
    typedef logic signed [COORD_WIDTH+1:0]     mid_t;
    // Doubled direction and doubled box extent: difference of two coordinates
    typedef logic signed [COORD_WIDTH:0]       dir_t;
    typedef logic signed [COORD_WIDTH:0]       ext_t;
    // Absolute direction plus epsilon term, kept signed for the multipliers
    typedef logic signed [COORD_WIDTH+2:0]     adir_t;
    // World-axis compare width
    typedef logic signed [COORD_WIDTH+3:0]     wcmp_t;
    // Full-width products
    typedef logic signed [2*COORD_WIDTH+2:0]   pmd_t;
    typedef logic signed [2*COORD_WIDTH+3:0]   pea_t;
    // Cross-axis compare width
    typedef logic signed [2*COORD_WIDTH+4:0]   xcmp_t;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    // Low COORD_WIDTH bits of a field, sign-extended
    function automatic coord_t coord(input in_t v);
        return coord_t'($signed(v));
    endfunction

endpackage

// ===== rtl/segaabb_prep.sv =====
`timescale 1ns / 1ps

module segaabb_prep (
    input  logic                  clk,
    input  segaabb_pkg::stage_en_t en,
    input  segaabb_pkg::in_t      seg_s [3],
    input  segaabb_pkg::in_t      seg_e [3],
    input  segaabb_pkg::in_t      bmin  [3],
    input  segaabb_pkg::in_t      bmax  [3],
    input  segaabb_pkg::eps_t     eps,
    output segaabb_pkg::mid_t     m_out [3],
    output segaabb_pkg::dir_t     d_out [3],
    output segaabb_pkg::ext_t     e_out [3],
    output segaabb_pkg::adir_t    a_out [3],
    output logic                  wsep
);
    import segaabb_pkg::*;

    mid_t  m1_reg [3];
    mid_t  m1_next [3];
    dir_t  d1_reg [3];
    dir_t  d1_next [3];
    ext_t  e1_reg [3];
    ext_t  e1_next [3];

    mid_t  m2_reg [3];
    dir_t  d2_reg [3];
    ext_t  e2_reg [3];
    adir_t a2_reg [3];
    adir_t a2_next [3];
    logic  wsep2_reg;
    logic  wsep2_next;

    wcmp_t absm  [3];
    wcmp_t absd  [3];
    wcmp_t lim   [3];
    adir_t eps2;

    // Stage 1: doubled midpoint offset, direction and extent per axis
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m1_next[k] = mid_t'(coord(seg_s[k])) + mid_t'(coord(seg_e[k]))
                       - mid_t'(coord(bmin[k])) - mid_t'(coord(bmax[k]));
            d1_next[k] = dir_t'(coord(seg_e[k])) - dir_t'(coord(seg_s[k]));
            e1_next[k] = ext_t'(coord(bmax[k])) - ext_t'(coord(bmin[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            m1_reg <= m1_next;
            d1_reg <= d1_next;
            e1_reg <= e1_next;
        end
    end

    // Stage 2: world-axis tests and padded absolute directions
    always_comb
    begin
        eps2 = adir_t'({eps, 1'b0});
        wsep2_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            absm[k] = (m1_reg[k] < 0) ? -wcmp_t'(m1_reg[k]) : wcmp_t'(m1_reg[k]);
            absd[k] = (d1_reg[k] < 0) ? -wcmp_t'(d1_reg[k]) : wcmp_t'(d1_reg[k]);
            lim[k]  = wcmp_t'(e1_reg[k]) + absd[k];
            if (absm[k] > lim[k])
            begin
                wsep2_next = 1'b1;
            end
            a2_next[k] = adir_t'(absd[k]) + eps2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            m2_reg    <= m1_reg;
            d2_reg    <= d1_reg;
            e2_reg    <= e1_reg;
            a2_reg    <= a2_next;
            wsep2_reg <= wsep2_next;
        end
    end

    assign m_out = m2_reg;
    assign d_out = d2_reg;
    assign e_out = e2_reg;
    assign a_out = a2_reg;
    assign wsep  = wsep2_reg;

endmodule

// ===== rtl/segaabb_cross.sv =====
`timescale 1ns / 1ps

// One cross-product axis: |ma*db - mb*da| > ea*ab + eb*aa
module segaabb_cross (
    input  logic                   clk,
    input  segaabb_pkg::stage_en_t en,
    input  segaabb_pkg::mid_t      ma,
    input  segaabb_pkg::mid_t      mb,
    input  segaabb_pkg::dir_t      da,
    input  segaabb_pkg::dir_t      db,
    input  segaabb_pkg::ext_t      ea,
    input  segaabb_pkg::ext_t      eb,
    input  segaabb_pkg::adir_t     aa,
    input  segaabb_pkg::adir_t     ab,
    output logic                   sep
);
    import segaabb_pkg::*;

    pmd_t  p1_reg;
    pmd_t  p1_next;
    pmd_t  p2_reg;
    pmd_t  p2_next;
    pea_t  q1_reg;
    pea_t  q1_next;
    pea_t  q2_reg;
    pea_t  q2_next;

    xcmp_t diff;
    xcmp_t lhs_reg;
    xcmp_t lhs_next;
    xcmp_t rhs_reg;
    xcmp_t rhs_next;

    // Stage 3: four full-width products
    always_comb
    begin
        p1_next = pmd_t'(ma) * pmd_t'(db);
        p2_next = pmd_t'(mb) * pmd_t'(da);
        q1_next = pea_t'(ea) * pea_t'(ab);
        q2_next = pea_t'(eb) * pea_t'(aa);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            q1_reg <= q1_next;
            q2_reg <= q2_next;
        end
    end

    // Stage 4: projected offset magnitude and projected radius
    always_comb
    begin
        diff     = xcmp_t'(p1_reg) - xcmp_t'(p2_reg);
        lhs_next = (diff < 0) ? -diff : diff;
        rhs_next = xcmp_t'(q1_reg) + xcmp_t'(q2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
    end

    // Compare feeds the result register in the top level
    assign sep = (lhs_reg > rhs_reg);

endmodule

// ===== rtl/segment_aabb_overlap_test.sv =====
`timescale 1ns / 1ps

// Segment versus axis-aligned box overlap by separating axes (three world axes, then the
// segment direction crossed with each world axis), exact on doubled fixed-point values.
// One item enters per cycle while in_stall is low, and each item passes the stages in order:
// stage 1 forms midpoint offset, direction and extent, stage 2 runs the world-axis
// tests and pads |direction| with 2*parallel_epsilon, stage 3 holds the twelve products,
// stage 4 the cross-axis magnitudes, stage 5 the hit register. Each stage holds its
// item while the next one is full and stalled, so in_stall follows out_stall through
// the pipeline in the same cycle only when all five stages are full. parallel_epsilon
// resets to 1 and takes a write in any cycle (cfg_ready is always high); write it
// only while no item is in flight.
module segment_aabb_overlap_test (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  segaabb_pkg::eps_t      parallel_epsilon,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  segaabb_pkg::in_t       seg_start_x,
    input  segaabb_pkg::in_t       seg_start_y,
    input  segaabb_pkg::in_t       seg_start_z,
    input  segaabb_pkg::in_t       seg_end_x,
    input  segaabb_pkg::in_t       seg_end_y,
    input  segaabb_pkg::in_t       seg_end_z,
    input  segaabb_pkg::in_t       box_min_x,
    input  segaabb_pkg::in_t       box_min_y,
    input  segaabb_pkg::in_t       box_min_z,
    input  segaabb_pkg::in_t       box_max_x,
    input  segaabb_pkg::in_t       box_max_y,
    input  segaabb_pkg::in_t       box_max_z,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit
);
    import segaabb_pkg::*;

    eps_t      eps_reg;
    eps_t      eps_next;

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] rdy;
    stage_en_t  en;

    in_t       seg_s [3];
    in_t       seg_e [3];
    in_t       bmin  [3];
    in_t       bmax  [3];

    mid_t      m [3];
    dir_t      d [3];
    ext_t      e [3];
    adir_t     a [3];
    logic      wsep;
    logic [2:0] xsep;

    logic      wsep3_reg;
    logic      wsep4_reg;
    logic      hit_reg;
    logic      hit_next;

    logic      in_xfer;
    logic      out_xfer;

    // Config register
    assign cfg_ready = 1'b1;
    assign eps_next  = (cfg_valid && cfg_ready) ? parallel_epsilon : eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else
        begin
            eps_reg <= eps_next;
        end
    end

    // Pipeline control: a stage loads when empty or when its item moves on
    always_comb
    begin
        rdy[4] = !vld_reg[4] || !out_stall;
        for (int k = 3; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        en.s1 = rdy[0];
        en.s2 = rdy[1];
        en.s3 = rdy[2];
        en.s4 = rdy[3];
        en.s5 = rdy[4];

        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < 5; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[4];
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;

    // Axis vectors
    assign seg_s = '{seg_start_x, seg_start_y, seg_start_z};
    assign seg_e = '{seg_end_x, seg_end_y, seg_end_z};
    assign bmin  = '{box_min_x, box_min_y, box_min_z};
    assign bmax  = '{box_max_x, box_max_y, box_max_z};

    // Stages 1 and 2
    segaabb_prep u_prep (
        .clk   (clk),
        .en    (en),
        .seg_s (seg_s),
        .seg_e (seg_e),
        .bmin  (bmin),
        .bmax  (bmax),
        .eps   (eps_reg),
        .m_out (m),
        .d_out (d),
        .e_out (e),
        .a_out (a),
        .wsep  (wsep)
    );

    // Stages 3 and 4, one unit per cross axis
    segaabb_cross u_cross_x (
        .clk (clk), .en (en),
        .ma  (m[1]), .mb (m[2]), .da (d[1]), .db (d[2]),
        .ea  (e[1]), .eb (e[2]), .aa (a[1]), .ab (a[2]),
        .sep (xsep[0])
    );

    segaabb_cross u_cross_y (
        .clk (clk), .en (en),
        .ma  (m[2]), .mb (m[0]), .da (d[2]), .db (d[0]),
        .ea  (e[2]), .eb (e[0]), .aa (a[2]), .ab (a[0]),
        .sep (xsep[1])
    );

    segaabb_cross u_cross_z (
        .clk (clk), .en (en),
        .ma  (m[0]), .mb (m[1]), .da (d[0]), .db (d[1]),
        .ea  (e[0]), .eb (e[1]), .aa (a[0]), .ab (a[1]),
        .sep (xsep[2])
    );

    // World-axis verdict travels alongside the cross units
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            wsep3_reg <= wsep;
        end
        if (en.s4)
        begin
            wsep4_reg <= wsep3_reg;
        end
    end

    // Stage 5: result register
    assign hit_next = !(wsep4_reg || (|xsep));

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

    // Occupancy grows by one when an item enters and none leaves
    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !out_xfer) |=> ($countones(vld_reg) == $past($countones(vld_reg)) + 1))
        else $error("pipeline lost an entering item");

    // Occupancy drops by one when an item leaves and none enters
    a_fill_down: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_xfer && out_xfer) |=> ($countones(vld_reg) + 1 == $past($countones(vld_reg))))
        else $error("pipeline duplicated or dropped an item");

    // Input is held off only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_stall))
        else $error("input stalled with a bubble in the pipeline");

    // A held result keeps its value
    a_hit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(hit_reg))
        else $error("result changed while stalled");

endmodule
